// ===== hdl/shortest_span_of_array_degree_assert.svh =====
// Assertion macros for the shortest span of array degree block.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef SHORTEST_SPAN_OF_ARRAY_DEGREE_ASSERT_SVH
`define SHORTEST_SPAN_OF_ARRAY_DEGREE_ASSERT_SVH

// Same-cycle implication.
`define SSAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ssad_pkg.sv =====
`default_nettype none

package ssad_pkg;

    localparam int unsigned VALUE_W = 12;
    localparam int unsigned OUT_W = 17;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam int unsigned RECIP_SHIFT = 24;

    localparam int unsigned EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_CLEARED = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam logic [QPTR_W:0] QUEUE_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

    typedef struct packed {
        logic last;
        logic overflow;
    } item_flags_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'b01,
        BK_RUN   = 2'b10
    } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/ssad_channels.sv =====
`default_nettype none

interface ssad_in_if import ssad_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

interface ssad_out_if import ssad_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] shortest_length;
    logic [OUT_W-1:0] degree;
    logic             too_long;

    modport source (output valid, output shortest_length, output degree, output too_long,
                    input ready);
    modport sink (input valid, input shortest_length, input degree, input too_long,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/ssad_front.sv =====
`default_nettype none

module ssad_front import ssad_pkg::*; #(
    parameter int unsigned VALUE_COUNT = 4096,
    parameter int unsigned MAX_LEN = 65536,
    localparam int unsigned IW = $clog2(VALUE_COUNT),
    localparam int unsigned PW = $clog2(MAX_LEN)
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ssad_in_if.sink      items,
    output logic         push_valid,
    input  wire logic    push_ready,
    output logic [IW-1:0] push_idx,
    output logic [PW-1:0] push_here,
    output item_flags_t  push_flags
);

    localparam int unsigned CW = $clog2(MAX_LEN + 1);
    localparam int unsigned RECIP = (2 ** RECIP_SHIFT) / VALUE_COUNT;
    localparam int unsigned PROD_W = VALUE_W + RECIP_SHIFT;
    localparam int unsigned QN_W = VALUE_W + $clog2(VALUE_COUNT + 1);
    localparam logic [QN_W-1:0] COUNT_Q = QN_W'(VALUE_COUNT);

    logic               a_valid_reg;
    logic [VALUE_W-1:0] a_value_reg;
    logic [VALUE_W-1:0] a_quot_reg;
    logic [PW-1:0]      a_here_reg;
    item_flags_t        a_flags_reg;
    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      pos_next;

    logic               accept;
    logic               at_limit;
    logic [PW-1:0]      here;
    logic [PROD_W-1:0]  quot_prod;
    logic [QN_W-1:0]    quot_times_n;
    logic [QN_W-1:0]    rem_raw;
    logic [QN_W-1:0]    rem_fixed;

    assign items.ready = !a_valid_reg || push_ready;
    assign accept = items.valid && items.ready;

    assign at_limit = (pos_reg == CW'(MAX_LEN));
    assign here = at_limit ? PW'(MAX_LEN - 1) : pos_reg[PW-1:0];

    always_comb
    begin
        if (items.last)
        begin
            pos_next = '0;
        end
        else if (at_limit)
        begin
            pos_next = pos_reg;
        end
        else
        begin
            pos_next = pos_reg + CW'(1);
        end
    end

    // Estimate value / VALUE_COUNT by reciprocal; low by at most one.
    assign quot_prod = PROD_W'(items.value) * PROD_W'(RECIP);

    assign quot_times_n = QN_W'(a_quot_reg) * COUNT_Q;
    assign rem_raw = QN_W'(a_value_reg) - quot_times_n;
    assign rem_fixed = (rem_raw >= COUNT_Q) ? (rem_raw - COUNT_Q) : rem_raw;

    assign push_valid = a_valid_reg;
    assign push_idx = rem_fixed[IW-1:0];
    assign push_here = a_here_reg;
    assign push_flags = a_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            if (items.ready)
            begin
                a_valid_reg <= items.valid;
            end
            if (accept)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_value_reg <= items.value;
            a_quot_reg <= quot_prod[PROD_W-1:RECIP_SHIFT];
            a_here_reg <= here;
            a_flags_reg.last <= items.last;
            a_flags_reg.overflow <= at_limit;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ssad_queue.sv =====
`default_nettype none

module ssad_queue import ssad_pkg::*; #(
    parameter int unsigned DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic [DATA_W-1:0]      pop_data
);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != QUEUE_FULL);
    assign pop_valid = (fill_reg != '0);
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + (QPTR_W + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ssad_back.sv =====
`default_nettype none

module ssad_back import ssad_pkg::*; #(
    parameter int unsigned VALUE_COUNT = 4096,
    parameter int unsigned MAX_LEN = 65536,
    localparam int unsigned IW = $clog2(VALUE_COUNT),
    localparam int unsigned PW = $clog2(MAX_LEN)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire logic [IW-1:0] pop_idx,
    input  wire logic [PW-1:0] pop_here,
    input  wire item_flags_t   pop_flags,
    ssad_out_if.source         results
);

    localparam int unsigned CW = $clog2(MAX_LEN + 1);
    localparam int unsigned EW = EPOCH_W + CW;
    localparam int unsigned MW = (CW > OUT_W) ? CW : OUT_W;

    back_state_t       state_reg;
    logic [IW-1:0]     clr_idx_reg;
    logic [EPOCH_W-1:0] epoch_reg;

    logic [EW-1:0]     cnt_mem [VALUE_COUNT];
    logic [PW-1:0]     fpos_mem [VALUE_COUNT];
    logic [EW-1:0]     cnt_q_reg;
    logic [PW-1:0]     fpos_q_reg;

    logic              e_valid_reg;
    logic [IW-1:0]     e_idx_reg;
    logic [PW-1:0]     e_here_reg;
    item_flags_t       e_flags_reg;

    logic              wr_valid_reg;
    logic [IW-1:0]     wr_idx_reg;
    logic [EW-1:0]     wr_entry_reg;
    logic [PW-1:0]     wr_fpos_reg;

    logic [CW-1:0]     best_deg_reg;
    logic [CW-1:0]     best_span_reg;
    logic              ovf_reg;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_len_reg;
    logic [OUT_W-1:0]  out_deg_reg;
    logic              out_ovf_reg;

    logic              out_free;
    logic              e_fire;
    logic              e_wrap;
    logic              do_pop;
    logic              fwd_hit;
    logic [EW-1:0]     entry_raw;
    logic [PW-1:0]     fpos_raw;
    logic [CW-1:0]     cnt_old;
    logic [CW-1:0]     cnt_new;
    logic [PW-1:0]     fpos;
    logic [CW-1:0]     span;
    logic              deg_up;
    logic              tie_better;
    logic [CW-1:0]     best_deg_next;
    logic [CW-1:0]     best_span_next;
    logic              ovf_next;
    logic [MW-1:0]     span_wide;
    logic [MW-1:0]     deg_wide;
    logic [OUT_W-1:0]  len_sat;
    logic [OUT_W-1:0]  deg_sat;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [EW-1:0]     mem_wdata;

    assign out_free = !out_valid_reg || results.ready;
    assign e_fire = e_valid_reg && (!e_flags_reg.last || out_free);
    assign e_wrap = e_valid_reg && e_flags_reg.last && (epoch_reg == EPOCH_LAST);
    assign pop_ready = (state_reg == BK_RUN) && (!e_valid_reg || e_fire) && !e_wrap;
    assign do_pop = pop_valid && pop_ready;

    // Forward the write that landed on the same edge as this entry's read.
    assign fwd_hit = wr_valid_reg && (wr_idx_reg == e_idx_reg);
    assign entry_raw = fwd_hit ? wr_entry_reg : cnt_q_reg;
    assign fpos_raw = fwd_hit ? wr_fpos_reg : fpos_q_reg;

    assign cnt_old = (entry_raw[EW-1:CW] == epoch_reg) ? entry_raw[CW-1:0] : '0;
    assign fpos = (cnt_old == '0) ? e_here_reg : fpos_raw;
    assign cnt_new = (cnt_old < CW'(MAX_LEN)) ? (cnt_old + CW'(1)) : cnt_old;
    assign span = CW'(e_here_reg) - CW'(fpos) + CW'(1);

    assign deg_up = (cnt_new > best_deg_reg);
    assign tie_better = (cnt_new == best_deg_reg) && (span < best_span_reg);
    assign best_deg_next = deg_up ? cnt_new : best_deg_reg;
    assign best_span_next = (deg_up || tie_better) ? span : best_span_reg;
    assign ovf_next = ovf_reg || e_flags_reg.overflow;

    assign span_wide = MW'(best_span_next);
    assign deg_wide = MW'(best_deg_next);
    assign len_sat = (span_wide > MW'(OUT_MAX)) ? OUT_MAX : span_wide[OUT_W-1:0];
    assign deg_sat = (deg_wide > MW'(OUT_MAX)) ? OUT_MAX : deg_wide[OUT_W-1:0];

    assign results.valid = out_valid_reg;
    assign results.shortest_length = out_len_reg;
    assign results.degree = out_deg_reg;
    assign results.too_long = out_ovf_reg;

    always_comb
    begin
        case (state_reg)
            BK_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = {EPOCH_CLEARED, CW'(0)};
            end
            BK_RUN:
            begin
                mem_we = e_fire;
                mem_waddr = e_idx_reg;
                mem_wdata = {epoch_reg, cnt_new};
            end
            default:
            begin
                mem_we = 1'b0;
                mem_waddr = e_idx_reg;
                mem_wdata = {epoch_reg, cnt_new};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[mem_waddr] <= mem_wdata;
        end
        if (do_pop)
        begin
            cnt_q_reg <= cnt_mem[pop_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_fire)
        begin
            fpos_mem[e_idx_reg] <= fpos;
        end
        if (do_pop)
        begin
            fpos_q_reg <= fpos_mem[pop_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_idx_reg <= '0;
            epoch_reg <= EPOCH_FIRST;
            e_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
            best_deg_reg <= '0;
            best_span_reg <= '0;
            ovf_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                BK_CLEAR:
                begin
                    wr_valid_reg <= 1'b0;
                    clr_idx_reg <= clr_idx_reg + IW'(1);
                    if (clr_idx_reg == IW'(VALUE_COUNT - 1))
                    begin
                        state_reg <= BK_RUN;
                        epoch_reg <= EPOCH_FIRST;
                    end
                end
                BK_RUN:
                begin
                    if (e_fire)
                    begin
                        wr_valid_reg <= 1'b1;
                        if (e_flags_reg.last)
                        begin
                            if (e_wrap)
                            begin
                                state_reg <= BK_CLEAR;
                                clr_idx_reg <= '0;
                            end
                            else
                            begin
                                epoch_reg <= epoch_reg + EPOCH_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= BK_CLEAR;
                    clr_idx_reg <= '0;
                end
            endcase

            if (do_pop)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_fire)
            begin
                e_valid_reg <= 1'b0;
            end

            if (e_fire)
            begin
                if (e_flags_reg.last)
                begin
                    best_deg_reg <= '0;
                    best_span_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    best_deg_reg <= best_deg_next;
                    best_span_reg <= best_span_next;
                    ovf_reg <= ovf_next;
                end
            end

            if (e_fire && e_flags_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            e_idx_reg <= pop_idx;
            e_here_reg <= pop_here;
            e_flags_reg <= pop_flags;
        end
        if (e_fire)
        begin
            wr_idx_reg <= e_idx_reg;
            wr_entry_reg <= {epoch_reg, cnt_new};
            wr_fpos_reg <= fpos;
        end
        if (e_fire && e_flags_reg.last)
        begin
            out_len_reg <= len_sat;
            out_deg_reg <= deg_sat;
            out_ovf_reg <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/shortest_span_of_array_degree.sv =====
// Throughput: one element per cycle, back to back, through one count-table
//   read-modify-write per cycle with forwarding for repeated values, unless a
//   table sweep runs or a last element waits on the stalled result register.
// Path: front register, queue, entry register, result register; the result
//   waits there while stalled. Reset: control clears at once; the count table
//   is then swept, and again after every 255th array; elements queue meanwhile.
`default_nettype none

module shortest_span_of_array_degree import ssad_pkg::*; #(
    parameter int unsigned VALUE_COUNT = 4096,
    parameter int unsigned MAX_LEN = 65536
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ssad_in_if.sink    items,
    ssad_out_if.source results
);

    localparam int unsigned IW = $clog2(VALUE_COUNT);
    localparam int unsigned PW = $clog2(MAX_LEN);
    localparam int unsigned FW = $bits(item_flags_t);
    localparam int unsigned QW = IW + PW + FW;

    logic          push_valid;
    logic          push_ready;
    logic [IW-1:0] push_idx;
    logic [PW-1:0] push_here;
    item_flags_t   push_flags;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;
    logic [IW-1:0] pop_idx;
    logic [PW-1:0] pop_here;
    item_flags_t   pop_flags;

    ssad_front #(
        .VALUE_COUNT (VALUE_COUNT),
        .MAX_LEN     (MAX_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_idx   (push_idx),
        .push_here  (push_here),
        .push_flags (push_flags)
    );

    ssad_queue #(
        .DATA_W (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_idx, push_here, push_flags}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_idx = pop_data[QW-1:PW+FW];
    assign pop_here = pop_data[PW+FW-1:FW];
    assign pop_flags = item_flags_t'(pop_data[FW-1:0]);

    ssad_back #(
        .VALUE_COUNT (VALUE_COUNT),
        .MAX_LEN     (MAX_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_idx   (pop_idx),
        .pop_here  (pop_here),
        .pop_flags (pop_flags),
        .results   (results)
    );

endmodule

`default_nettype wire

// ===== hdl/ssad_checker.sv =====
`default_nettype none

`include "shortest_span_of_array_degree_assert.svh"

module ssad_checker import ssad_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [OUT_W-1:0] out_len,
    input wire logic [OUT_W-1:0] out_deg,
    input wire logic             out_too_long
);

    logic [2*OUT_W:0] out_word;

    assign out_word = {out_len, out_deg, out_too_long};

    `SSAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `SSAD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word), "result changed")
    `SSAD_ASSERT_NOW(a_deg_nonzero, out_valid, out_deg != '0, "degree of zero")
    `SSAD_ASSERT_NOW(a_len_covers_deg, out_valid && !out_too_long, out_len >= out_deg, "short span")

endmodule

bind shortest_span_of_array_degree ssad_checker u_ssad_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_len      (results.shortest_length),
    .out_deg      (results.degree),
    .out_too_long (results.too_long)
);

`default_nettype wire

// ===== sim/tb_shortest_span_of_array_degree.sv =====
module tb_shortest_span_of_array_degree;
    import ssad_pkg::*;

    localparam int unsigned TABLE_SIZE = 4096;
    localparam int unsigned LEN_LIMIT = 65536;
    localparam int unsigned HALF_PERIOD = 5;
    localparam int unsigned IDLE_PCT = 29;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_ARRAYS = 40;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned STEADY_ELEMENTS = 200;
    localparam int unsigned TOTAL_ELEMENTS = 1800;
    localparam int unsigned MIN_ARRAYS = 260;
    localparam int unsigned DRAIN_EVERY = 64;
    localparam int unsigned POOL_MAX = 5;
    localparam longint unsigned LIMIT_CYCLES = 200000;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } element_t;

    typedef struct packed {
        logic [OUT_W-1:0] span;
        logic [OUT_W-1:0] degree;
        logic             too_long;
    } span_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ssad_in_if  in_ch ();
    ssad_out_if out_ch ();

    shortest_span_of_array_degree #(
        .VALUE_COUNT(TABLE_SIZE),
        .MAX_LEN(LEN_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .items(in_ch),
        .results(out_ch)
    );

    // element-side model state
    bit [OUT_W-1:0] elem_count [TABLE_SIZE];
    bit [15:0]      elem_first [TABLE_SIZE];
    int unsigned    run_pos;
    int unsigned    top_degree;
    int unsigned    top_span;
    bit             ran_long;

    span_result_t expected_spans [$];
    element_t     element_queue [$];

    int unsigned queued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned arrays_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;

    bit          steady = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [OUT_W-1:0] clip_out(input int unsigned v);
        return (v > OUT_MAX) ? OUT_MAX : OUT_W'(v);
    endfunction

    task automatic clear_tables();
        for (int unsigned k = 0; k < TABLE_SIZE; k++)
        begin
            elem_count[k] = '0;
            elem_first[k] = '0;
        end
        run_pos = 0;
        top_degree = 0;
        top_span = 0;
        ran_long = 1'b0;
    endtask

    task automatic absorb_element(input logic [VALUE_W-1:0] value, input logic last);
        int unsigned  slot;
        int unsigned  here;
        int unsigned  cnt;
        int unsigned  span;
        span_result_t res;
        slot = value % TABLE_SIZE;
        if (run_pos >= LEN_LIMIT)
        begin
            ran_long = 1'b1;
            here = LEN_LIMIT - 1;
        end
        else
        begin
            here = run_pos;
            run_pos++;
        end
        cnt = elem_count[slot];
        if (cnt == 0)
            elem_first[slot] = 16'(here);
        if (cnt < LEN_LIMIT)
            cnt++;
        elem_count[slot] = OUT_W'(cnt);
        span = here - elem_first[slot] + 1;
        if (cnt > top_degree)
        begin
            top_degree = cnt;
            top_span = span;
        end
        else if (cnt == top_degree && span < top_span)
            top_span = span;
        if (last)
        begin
            res.span = clip_out(top_span);
            res.degree = clip_out(top_degree);
            res.too_long = ran_long;
            expected_spans.insert(expected_spans.size(), res);
            clear_tables();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic push_element(input logic [VALUE_W-1:0] value, input logic last);
        element_t e;
        e.value = value;
        e.last = last;
        element_queue.insert(element_queue.size(), e);
        queued_count++;
        if (last)
            arrays_sent++;
    endtask

    task automatic push_random_array();
        logic [VALUE_W-1:0] pool [POOL_MAX];
        int unsigned        pool_n;
        int unsigned        len;
        int unsigned        pick;
        bit                 noise;
        pick = $urandom_range(99);
        if (pick < 40)
            len = $urandom_range(3, 1);
        else if (pick < 80)
            len = $urandom_range(10, 4);
        else if (pick < 97)
            len = $urandom_range(30, 11);
        else
            len = $urandom_range(60, 31);
        pool_n = $urandom_range(POOL_MAX, 1);
        for (int unsigned k = 0; k < POOL_MAX; k++)
            pool[k] = VALUE_W'($urandom);
        noise = ($urandom_range(9) == 0);
        for (int unsigned k = 0; k < len; k++)
            push_element(noise ? VALUE_W'($urandom) : pool[$urandom_range(pool_n - 1)],
                         k == len - 1);
    endtask

    task automatic wait_drained();
        wait (accepted_count == queued_count && expected_spans.size() == 0);
        @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive
        element_t nxt;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.value <= '0;
            in_ch.last <= 1'b0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (element_queue.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt = element_queue.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.value <= nxt.value;
                in_ch.last <= nxt.last;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin : watch
        span_result_t got;
        span_result_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                absorb_element(in_ch.value, in_ch.last);
                accepted_count++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.span = out_ch.shortest_length;
                got.degree = out_ch.degree;
                got.too_long = out_ch.too_long;
                results_seen++;
                if (expected_spans.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none pending",
                                              results_seen));
                else
                begin
                    want = expected_spans.pop_front();
                    if (got.span !== want.span)
                        report_mismatch($sformatf("result %0d shortest_length %0d, want %0d",
                                                  results_seen, got.span, want.span));
                    if (got.degree !== want.degree)
                        report_mismatch($sformatf("result %0d degree %0d, want %0d",
                                                  results_seen, got.degree, want.degree));
                    if (got.too_long !== want.too_long)
                        report_mismatch($sformatf("result %0d too_long %0b, want %0b",
                                                  results_seen, got.too_long, want.too_long));
                end
            end
        end
    end

    initial
    begin : stimulus
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        clear_tables();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        push_element(12'd0, 1'b1);
        push_element(12'hFFF, 1'b1);
        push_element(12'hAAA, 1'b0);
        push_element(12'h555, 1'b0);
        push_element(12'hFFF, 1'b1);
        push_element(12'd3, 1'b0);
        push_element(12'd1, 1'b0);
        push_element(12'd3, 1'b0);
        push_element(12'd1, 1'b0);
        push_element(12'd2, 1'b1);
        push_element(12'd1, 1'b0);
        push_element(12'd2, 1'b0);
        push_element(12'd2, 1'b0);
        push_element(12'd3, 1'b0);
        push_element(12'd1, 1'b0);
        push_element(12'd4, 1'b0);
        push_element(12'd2, 1'b1);
        push_element(12'd7, 1'b0);
        push_element(12'd7, 1'b1);
        push_element(12'd4, 1'b0);
        push_element(12'd8, 1'b0);
        push_element(12'd8, 1'b0);
        push_element(12'd4, 1'b1);
        wait_drained();

        // no idling on either side
        steady = 1'b1;
        while (queued_count < STEADY_ELEMENTS)
            push_random_array();
        wait_drained();
        steady = 1'b0;

        // hold results while single-element arrays keep coming
        hold_req = 1'b1;
        for (int unsigned k = 0; k < HOLD_ARRAYS; k++)
            push_element(VALUE_W'($urandom), 1'b1);
        wait_drained();

        while (queued_count < TOTAL_ELEMENTS || arrays_sent < MIN_ARRAYS)
        begin
            push_random_array();
            if (arrays_sent % DRAIN_EVERY == 0)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run covered %0d arrays and %0d elements, a no-idle stretch and a held output",
                 arrays_sent, accepted_count);
        $display("%0d results compared, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
